[rtl/ssm_pkg.sv]
// Shared types and constants for the sorted span merge table.
package ssm_pkg;

   // Table depth and the widths that follow from it.
   localparam int MAX_SPANS = 16;
   localparam int IDX_W     = $clog2(MAX_SPANS);
   localparam int CNT_W     = $clog2(MAX_SPANS + 1);

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_MERGED   = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_APPENDED = 3'd2,
      STAT_DROPPED  = 3'd3,
      STAT_EMITTED  = 3'd4
   } status_type;

   // Decoded command held in the front queue; xe is the exclusive end x + w.
   typedef struct packed {
      logic               emit;
      logic               solid;
      logic signed [15:0] x;
      logic        [14:0] w;
      logic signed [17:0] xe;
   } cmd_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // One result word.
   typedef struct packed {
      status_type         status;
      logic signed [15:0] start;
      logic        [15:0] width;
      logic        [4:0]  count;
      logic               valid;
      logic               last;
   } rsp_type;

endpackage

[rtl/ssm_front.sv]
// Front end: accepts request words, decodes them and queues them for the back end.
module ssm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,
   input  logic [0:0]        req_tuser,
   output ssm_pkg::head_type head,
   input  logic              head_pop
);

   // Two-entry queue.
   ssm_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   ssm_pkg::cmd_type dec;
   logic             push, pop;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign pop        = head_pop & head.valid;

   always_comb begin
      dec.emit  = req_tuser[0];
      dec.x     = $signed(req_tdata[15:0]);
      dec.w     = req_tdata[30:16];
      dec.solid = req_tdata[31];
      dec.xe    = $signed({{2{req_tdata[15]}}, req_tdata[15:0]})
                  + $signed({3'b000, req_tdata[30:16]});
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/ssm_back.sv]
// Back end: span table, parallel compare, merge/insert/append and emit sequencing.
module ssm_back (
   input  logic              clock,
   input  logic              reset,
   input  ssm_pkg::head_type head,
   output logic              head_pop,
   output logic              rsp_valid,
   output ssm_pkg::rsp_type  rsp,
   input  logic              rsp_ready
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_APPLY = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Span table.
   logic signed [15:0] starts_ff [ssm_pkg::MAX_SPANS];
   logic signed [15:0] starts_in [ssm_pkg::MAX_SPANS];
   logic        [15:0] widths_ff [ssm_pkg::MAX_SPANS];
   logic        [15:0] widths_in [ssm_pkg::MAX_SPANS];
   logic [ssm_pkg::CNT_W-1:0] count_ff, count_in;

   // Per-entry compare.
   logic signed [17:0] ent_start [ssm_pkg::MAX_SPANS];
   logic signed [17:0] ent_end   [ssm_pkg::MAX_SPANS];
   logic [ssm_pkg::MAX_SPANS-1:0] ent_hit, ent_stop;
   logic signed [17:0] head_x18;

   // Compare results, registered for the apply step.
   ssm_pkg::cmd_type cmd_ff;
   logic [ssm_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic found_ff, found_in, hit_ff, hit_in;
   logic signed [17:0] px_ff, px_in, pe_ff, pe_in;

   // Apply step.
   logic signed [17:0] cmd_x18, ns, ne, nw;
   logic [15:0] nw_sat;
   logic full, out_free, out_load;

   ssm_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign head_pop  = (state_ff == S_IDLE);
   assign full      = (count_ff == ssm_pkg::CNT_W'(ssm_pkg::MAX_SPANS));

   assign head_x18 = $signed({{2{head.cmd.x[15]}}, head.cmd.x});
   assign cmd_x18  = $signed({{2{cmd_ff.x[15]}}, cmd_ff.x});

   // Closed-interval overlap (touching counts) or solid mode; stop at first
   // entry hit or lying wholly after the new span.
   always_comb begin
      for (int i = 0; i < ssm_pkg::MAX_SPANS; i++) begin
         ent_start[i] = $signed({{2{starts_ff[i][15]}}, starts_ff[i]});
         ent_end[i]   = ent_start[i] + $signed({2'b00, widths_ff[i]});
         ent_hit[i]   = head.cmd.solid
                        || ((head_x18 <= ent_end[i]) && (ent_start[i] <= head.cmd.xe));
         ent_stop[i]  = (ssm_pkg::CNT_W'(i) < count_ff)
                        && (ent_hit[i] || (head.cmd.xe < ent_start[i]));
      end
   end

   // Priority pick of the lowest stopping entry.
   always_comb begin
      found_in = 1'b0;
      hit_in   = 1'b0;
      idx_in   = '0;
      px_in    = '0;
      pe_in    = '0;
      for (int i = ssm_pkg::MAX_SPANS - 1; i >= 0; i--) begin
         if (ent_stop[i]) begin
            found_in = 1'b1;
            hit_in   = ent_hit[i];
            idx_in   = ssm_pkg::IDX_W'(i);
            px_in    = ent_start[i];
            pe_in    = ent_end[i];
         end
      end
   end

   // Union of the new span and the picked entry, width saturated.
   always_comb begin
      ns     = (px_ff < cmd_x18) ? px_ff : cmd_x18;
      ne     = (cmd_ff.xe > pe_ff) ? cmd_ff.xe : pe_ff;
      nw     = ne - ns;
      nw_sat = (nw[17:16] != 2'b00) ? 16'hFFFF : nw[15:0];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      starts_in    = starts_ff;
      widths_in    = widths_ff;
      out_load     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               state_in = head.cmd.emit ? S_EMIT : S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               if (found_ff && hit_ff) begin
                  starts_in[idx_ff] = ns[15:0];
                  widths_in[idx_ff] = nw_sat;
                  rsp_in.status     = ssm_pkg::STAT_MERGED;
               end else if (full) begin
                  rsp_in.status = ssm_pkg::STAT_DROPPED;
               end else if (found_ff) begin
                  for (int j = 1; j < ssm_pkg::MAX_SPANS; j++) begin
                     if (ssm_pkg::IDX_W'(j) > idx_ff) begin
                        starts_in[j] = starts_ff[j-1];
                        widths_in[j] = widths_ff[j-1];
                     end
                  end
                  starts_in[idx_ff] = cmd_ff.x;
                  widths_in[idx_ff] = {1'b0, cmd_ff.w};
                  count_in          = count_ff + 1'b1;
                  rsp_in.status     = ssm_pkg::STAT_INSERTED;
               end else begin
                  starts_in[count_ff[ssm_pkg::IDX_W-1:0]] = cmd_ff.x;
                  widths_in[count_ff[ssm_pkg::IDX_W-1:0]] = {1'b0, cmd_ff.w};
                  count_in      = count_ff + 1'b1;
                  rsp_in.status = ssm_pkg::STAT_APPENDED;
               end
               rsp_in.start = '0;
               rsp_in.width = '0;
               rsp_in.count = 5'(count_in);
               rsp_in.valid = 1'b0;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_in.status = ssm_pkg::STAT_EMITTED;
               rsp_in.count  = '0;
               if (count_ff == '0) begin
                  rsp_in.start = '0;
                  rsp_in.width = '0;
                  rsp_in.valid = 1'b0;
                  rsp_in.last  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  // Head of the table goes out, the rest shifts down.
                  rsp_in.start = starts_ff[0];
                  rsp_in.width = widths_ff[0];
                  rsp_in.valid = 1'b1;
                  rsp_in.last  = (count_ff == ssm_pkg::CNT_W'(1));
                  for (int j = 0; j < ssm_pkg::MAX_SPANS - 1; j++) begin
                     starts_in[j] = starts_ff[j+1];
                     widths_in[j] = widths_ff[j+1];
                  end
                  count_in = count_ff - 1'b1;
                  if (count_ff == ssm_pkg::CNT_W'(1)) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      starts_ff <= starts_in;
      widths_ff <= widths_in;
      rsp_ff    <= rsp_in;
      if (state_ff == S_IDLE) begin
         cmd_ff   <= head.cmd;
         idx_ff   <= idx_in;
         found_ff <= found_in;
         hit_ff   <= hit_in;
         px_ff    <= px_in;
         pe_ff    <= pe_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/sorted_span_merge_table.sv]
// Top level of the sorted span merge table.
//
// Holds one raster row of up to ssm_pkg::MAX_SPANS spans (start, width),
// sorted by start. An add word merges into the first stored span it overlaps
// or touches (any first span in solid mode), is inserted before the first
// span it ends ahead of, or is appended; a full table drops it. Each add
// gives one response word. An emit word streams every stored span, tlast on
// the final one, and clears the table; on an empty table it gives a single
// word with no span. Timing: a front end decodes requests into a two-entry
// queue, so up to two requests are taken while the back end is busy. The
// back end does an add in two steps (the parallel compare of the new span
// against all entries and the pick of the first match, registered in idle;
// then the table update and the response register load in apply) and an
// emit one span per cycle through the table's shift path, while the
// response register is not stalled. A stalled response register holds the
// back end, not the front queue. No clearing pass is needed after reset.
module sorted_span_merge_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] span_start, [30:16] span_width, [31] solid_mode
   input  logic [31:0] req_tdata,
   // [0] action
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] out_start, [31:16] out_width, [36:32] span_count, [39:37] zero
   output logic [39:0] rsp_tdata,
   // [2:0] status, [3] span_valid
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast
);

   ssm_pkg::head_type head;
   logic              head_pop;
   ssm_pkg::rsp_type  rsp;

   ssm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .head_pop   (head_pop)
   );

   ssm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .rsp_ready (rsp_tready)
   );

   // Response word packing.
   assign rsp_tdata = {3'b000, rsp.count, rsp.width, rsp.start};
   assign rsp_tuser = {rsp.valid, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

[rtl/ssm_checker.sv]
// Port-level checker for the sorted span merge table, with its bind.
module ssm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // Only emit words carry a span.
   a_valid_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ssm_pkg::STAT_EMITTED)
      else $error("span marked valid on a non-emit word");

   // Add responses are single, spanless words.
   a_add_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != ssm_pkg::STAT_EMITTED
         |-> rsp_tlast && !rsp_tuser[3] && rsp_tdata[31:0] == 32'd0)
      else $error("add response malformed");

   // Emit words report a zero span count.
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ssm_pkg::STAT_EMITTED |-> rsp_tdata[36:32] == 5'd0)
      else $error("emit word reports nonzero count");

   // Drops happen only on a full table.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ssm_pkg::STAT_DROPPED
         |-> rsp_tdata[36:32] == 5'(ssm_pkg::MAX_SPANS))
      else $error("drop reported on a table that is not full");

endmodule

bind sorted_span_merge_table ssm_checker u_ssm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[sim/span_table_checker.sv]
// Checker for the sorted span merge table: predicts the span row and compares every result word.
`timescale 1ns / 100ps

module span_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);

   // predicted row contents; only entries below row_len are ever read
   logic signed [15:0] row_x [ssm_pkg::MAX_SPANS];
   logic        [15:0] row_w [ssm_pkg::MAX_SPANS];
   int                 row_len;
   ssm_pkg::rsp_type   due_words [$];

   // Queue one expected word at the back.
   function automatic void queue_word(input ssm_pkg::rsp_type w);
      due_words = {due_words, w};
   endfunction

   // Fold one new span into the row, return what happened to it.
   function automatic ssm_pkg::status_type fold_span(input int x, input int w,
                                                     input logic solid);
      int xe, px, pe, ns, ne, nw, i, j;
      xe = x + w;
      for (i = 0; i < row_len; i++) begin
         px = row_x[i];
         pe = px + int'(row_w[i]);
         if (solid || (x >= px && x <= pe) || (xe >= px && xe <= pe) ||
             (px >= x && px <= xe) || (pe >= x && pe <= xe)) begin
            ns = (px < x) ? px : x;
            ne = (xe > pe) ? xe : pe;
            nw = ne - ns;
            if (nw > 65535) nw = 65535;
            row_x[i] = ns[15:0];
            row_w[i] = nw[15:0];
            return ssm_pkg::STAT_MERGED;
         end
         if (xe < px) begin
            if (row_len >= ssm_pkg::MAX_SPANS) return ssm_pkg::STAT_DROPPED;
            for (j = row_len; j > i; j--) begin
               row_x[j] = row_x[j-1];
               row_w[j] = row_w[j-1];
            end
            row_x[i] = x[15:0];
            row_w[i] = w[15:0];
            row_len++;
            return ssm_pkg::STAT_INSERTED;
         end
      end
      if (row_len >= ssm_pkg::MAX_SPANS) return ssm_pkg::STAT_DROPPED;
      row_x[row_len] = x[15:0];
      row_w[row_len] = w[15:0];
      row_len++;
      return ssm_pkg::STAT_APPENDED;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      ssm_pkg::rsp_type word;
      int               i;
      if (reset) begin
         row_len = 0;
         due_words.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               // emit: stream the row, then clear it
               if (row_len == 0) begin
                  word = '0;
                  word.status = ssm_pkg::STAT_EMITTED;
                  word.last = 1'b1;
                  queue_word(word);
               end else begin
                  for (i = 0; i < row_len; i++) begin
                     word = '0;
                     word.status = ssm_pkg::STAT_EMITTED;
                     word.start = row_x[i];
                     word.width = row_w[i];
                     word.valid = 1'b1;
                     word.last = (i == row_len - 1);
                     queue_word(word);
                  end
                  row_len = 0;
               end
            end else begin
               word = '0;
               word.status = fold_span($signed(req_tdata[15:0]), int'(req_tdata[30:16]),
                                       req_tdata[31]);
               word.count = row_len[4:0];
               word.last = 1'b1;
               queue_word(word);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_words.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected word, expected none, actual data 0x%h user 0x%h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               word = due_words.pop_front();
               check_field("status", word.status, rsp_tuser[2:0]);
               check_field("out_start", word.start, rsp_tdata[15:0]);
               check_field("out_width", word.width, rsp_tdata[31:16]);
               check_field("span_count", word.count, rsp_tdata[36:32]);
               check_field("span_valid", word.valid, rsp_tuser[3]);
               check_field("last", word.last, rsp_tlast);
            end
         end
      end
      pending <= due_words.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for the sorted span merge table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   // action codes carried in req_tuser
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_EMIT = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] span_start, [30:16] span_width, [31] solid_mode
   logic [0:0]  req_tuser = '0;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [15:0] out_start, [31:16] out_width, [36:32] span_count
   logic [3:0]  rsp_tuser;        // [2:0] status, [3] span_valid
   logic        rsp_tlast;
   int          fail_count;
   int          pending;

   // idle styles: 0 = never idle, 1 = a random gap before every word, 2 = occasional gaps
   int          req_style = 1;
   int          rsp_style = 1;
   int          rsp_hold = 0;

   always #2 clock = ~clock;

   sorted_span_merge_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   span_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int pick_gap(input int style);
      case (style)
         0:       return 0;
         1:       return $urandom_range(0, 11);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      endcase
   endfunction

   // Result side: after each taken word, drop tready for a random number of cycles.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_tready && rsp_tvalid) begin
         gap = pick_gap(rsp_style);
         rsp_hold <= (gap > 0) ? gap - 1 : 0;
         rsp_tready <= (gap == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one request word after an optional gap and hold it until taken.
   // tvalid is only lowered when a gap follows, so back-to-back words keep it high.
   task automatic send_word(input logic act, input logic [15:0] x, input logic [14:0] w,
                            input logic solid);
      int gap;
      gap = pick_gap(req_style);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {solid, w, x};
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int          sent, n_adds, k, i;
      logic [15:0] base, x;
      logic [14:0] w;
      logic [15:0] prev_x;
      logic [14:0] prev_w;
      logic        solid;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // emit on an empty row: single word with no span
      send_word(ACT_EMIT, 16'h0000, 15'd0, 1'b0);
      // solid add on an empty row appends; a second solid add merges into it and
      // the union (-32768 .. 65534) saturates the width at 65535
      send_word(ACT_ADD, 16'h7FFF, 15'h7FFF, 1'b1);
      send_word(ACT_ADD, 16'h8000, 15'h7FFF, 1'b1);
      send_word(ACT_EMIT, 16'hFFFF, 15'h7FFF, 1'b1);
      // fill the row back to front: first word appends, the rest insert at the head
      for (i = 0; i < 16; i++)
         send_word(ACT_ADD, 16'((15 - i) * 8), 15'd3, 1'b0);
      // full row: append path and insert path are both dropped
      send_word(ACT_ADD, 16'd200, 15'd1, 1'b0);
      send_word(ACT_ADD, -16'sd50, 15'd0, 1'b0);
      // merging still works when full; start touches the end of the first span
      send_word(ACT_ADD, 16'd3, 15'd5, 1'b0);
      send_word(ACT_EMIT, 16'h0000, 15'd0, 1'b0);

      // ---- random rows: a run of adds closed by an emit ----
      sent = 0;
      prev_x = 16'd0;
      prev_w = 15'd0;
      while (sent < 450) begin
         req_style = $urandom_range(0, 2);
         rsp_style = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0:       n_adds = 0;
            1, 2:    n_adds = $urandom_range(14, 22);  // reach and overrun a full row
            default: n_adds = $urandom_range(1, 10);
         endcase
         base = 16'($urandom);
         for (k = 0; k < n_adds; k++) begin
            w = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 40));
            case ($urandom_range(0, 9))
               0: begin   // noise
                  x = 16'($urandom);
                  w = 15'($urandom);
               end
               1: x = prev_x + 16'(prev_w);   // touch the end of the last span
               2: x = prev_x - 16'(w);        // end exactly at the last span's start
               default: x = base + 16'($urandom_range(0, 600));
            endcase
            solid = ($urandom_range(0, 11) == 0);
            send_word(ACT_ADD, x, w, solid);
            prev_x = x;
            prev_w = w;
         end
         // payload of an emit is ignored; randomize it anyway
         send_word(ACT_EMIT, 16'($urandom), 15'($urandom), 1'($urandom));
         sent += n_adds + 1;
      end
      req_tvalid <= 1'b0;

      // drain: let the last push land, then wait for every expected word
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/ssm_pkg.sv
rtl/ssm_front.sv
rtl/ssm_back.sv
rtl/sorted_span_merge_table.sv
rtl/ssm_checker.sv
sim/span_table_checker.sv
sim/tb.sv
